>>> design/lrfp_pkg.sv
`timescale 1ns / 1ps

package lrfp_pkg;

	// item opcodes
	localparam logic [1:0] OP_BYTE = 2'd0;
	localparam logic [1:0] OP_TICK = 2'd1;
	localparam logic [1:0] OP_ARM  = 2'd2;

	// configuration register indexes
	localparam logic [1:0] CFG_SYNC_FIRST  = 2'd0;
	localparam logic [1:0] CFG_SYNC_SECOND = 2'd1;
	localparam logic [1:0] CFG_TIMEOUT     = 2'd2;

	localparam logic [7:0]  SYNC_FIRST_RST  = 8'hAE;
	localparam logic [7:0]  SYNC_SECOND_RST = 8'hA7;
	localparam logic [15:0] TIMEOUT_RST     = 16'd1000;

	// result kinds
	localparam logic [2:0] KIND_DIST     = 3'd0;
	localparam logic [2:0] KIND_CONT_ON  = 3'd1;
	localparam logic [2:0] KIND_CONT_OFF = 3'd2;
	localparam logic [2:0] KIND_LASER    = 3'd3;
	localparam logic [2:0] KIND_OTHER    = 3'd4;
	localparam logic [2:0] KIND_OVERSIZE = 3'd5;
	localparam logic [2:0] KIND_TIMEOUT  = 3'd6;

	// frame constants
	localparam logic [7:0] LEN_DIST     = 8'h17;
	localparam logic [7:0] LEN_ACK      = 8'h04;
	localparam logic [7:0] CMD_DIST     = 8'h85;
	localparam logic [7:0] CMD_CONT_ON  = 8'h8E;
	localparam logic [7:0] CMD_CONT_OFF = 8'h8F;
	localparam logic [7:0] CMD_LASER    = 8'hC0;
	localparam logic [7:0] HDR_BYTES    = 8'd4;

	localparam logic [4:0] POS_SYNC2 = 5'd1;
	localparam logic [4:0] POS_LEN   = 5'd2;
	localparam logic [4:0] POS_BODY  = 5'd3;
	localparam logic [4:0] POS_CMD   = 5'd4;
	localparam logic [4:0] POS_DHI   = 5'd7;
	localparam logic [4:0] POS_DLO   = 5'd8;

	localparam logic [15:0] DIST_SCALE = 16'd10;

	typedef enum logic [1:0] {
		PH_SYNC1,
		PH_SYNC2,
		PH_LEN,
		PH_BODY
	} phase_t;

	// request from the parser to the result stage
	typedef struct packed {
		logic [2:0] kind;
		logic [7:0] dist_hi;
		logic [7:0] dist_lo;
	} req_t;

	typedef struct packed {
		logic [2:0]  kind;
		logic [15:0] dist_cm;
	} res_t;

endpackage

>>> design/lidar_response_frame_parser_core.sv
// Path: with the output side idle, the request is written to the request queue at the edge
// that accepts the byte or tick that causes it; its result then passes the output queue to the ports.
// Throughput: one item per cycle while full is low; the parser state updates on each accepted
// item, and the request queue plus a 2-entry output queue absorb result-side stalls.
// Reset (arst_n low, asynchronous): parser state, timer and queues clear, the
// configuration registers return to their defaults.
`timescale 1ns / 1ps

module lidar_response_frame_parser_core #(
	parameter int MAX_FRAME_BYTES = 27,
	parameter int QUEUE_DEPTH     = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [1:0]  opcode,
	input  logic [7:0]  rx_byte,
	output logic        empty,
	input  logic        pop,
	output logic [2:0]  frame_kind,
	output logic [15:0] distance_cm,
	input  logic        wr_en,
	input  logic [1:0]  wr_index,
	input  logic [15:0] wr_data
);
	import lrfp_pkg::*;

	logic accept, req_valid, mid_empty, mid_pop;
	req_t req_in, req_out;

	assign accept = push && !full;

	lrfp_front #(
		.MAX_FRAME_BYTES(MAX_FRAME_BYTES)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.accept   (accept),
		.opcode   (opcode),
		.rx_byte  (rx_byte),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data),
		.req_valid(req_valid),
		.req      (req_in)
	);

	lrfp_fifo #(
		.WIDTH($bits(req_t)),
		.DEPTH(QUEUE_DEPTH)
	) u_mid_q (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (req_valid),
		.wdata (req_in),
		.full  (full),
		.pop   (mid_pop),
		.rdata (req_out),
		.empty (mid_empty)
	);

	lrfp_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_empty  (mid_empty),
		.req        (req_out),
		.req_pop    (mid_pop),
		.empty      (empty),
		.pop        (pop),
		.frame_kind (frame_kind),
		.distance_cm(distance_cm)
	);

`ifndef ASSERT_OFF
	a_kind_range: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> (frame_kind <= KIND_TIMEOUT))
		else $error("result kind out of range");

	a_dist_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && frame_kind != KIND_DIST) |-> (distance_cm == 16'd0))
		else $error("nonzero distance on non-distance result");

	a_no_bypass: assert property (@(posedge clk) disable iff (!arst_n)
		(empty && mid_empty) |=> empty)
		else $error("result appeared without passing the request queue");
`endif

endmodule

>>> design/lrfp_fifo.sv
`timescale 1ns / 1ps

module lrfp_fifo #(
	parameter int WIDTH = 19,
	parameter int DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata,
	output logic             empty
);
	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push, do_pop;

	assign full    = (count_q == CNT_W'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

>>> design/lrfp_front.sv
`timescale 1ns / 1ps

module lrfp_front #(
	parameter int MAX_FRAME_BYTES = 27
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          accept,
	input  logic [1:0]    opcode,
	input  logic [7:0]    rx_byte,
	input  logic          wr_en,
	input  logic [1:0]    wr_index,
	input  logic [15:0]   wr_data,
	output logic          req_valid,
	output lrfp_pkg::req_t req
);
	import lrfp_pkg::*;

	localparam logic [7:0] MAX_LEN = 8'(MAX_FRAME_BYTES - 4);

	logic [7:0]  sync_first_q, sync_second_q;
	logic [15:0] timeout_q;

	phase_t      phase_q, phase_d;
	logic [4:0]  pos_q, pos_d, total_q, total_d;
	logic [7:0]  len_q, len_d, cmd_q, cmd_d, dhi_q, dhi_d, dlo_q, dlo_d;
	logic [15:0] ticks_q, ticks_d;
	logic        armed_q, armed_d;
	logic [4:0]  pos_inc;
	logic [7:0]  total_sum;
	logic        is_byte, oversize, frame_done;

	assign is_byte   = accept && (opcode == OP_BYTE);
	assign oversize  = (rx_byte > MAX_LEN);
	assign pos_inc   = pos_q + 5'd1;
	assign total_sum = rx_byte + HDR_BYTES;
	assign frame_done = (pos_inc >= total_q);

	// next phase
	always_comb begin
		phase_d = phase_q;
		if (accept && opcode == OP_ARM) begin
			phase_d = PH_SYNC1;
		end else if (is_byte) begin
			unique case (phase_q)
				PH_SYNC1: if (rx_byte == sync_first_q) phase_d = PH_SYNC2;
				PH_SYNC2: phase_d = (rx_byte == sync_second_q) ? PH_LEN : PH_SYNC1;
				PH_LEN:   phase_d = oversize ? PH_SYNC1 : PH_BODY;
				PH_BODY:  if (frame_done) phase_d = PH_SYNC1;
				default:  phase_d = PH_SYNC1;
			endcase
		end
	end

	// datapath and result request
	always_comb begin
		pos_d     = pos_q;
		total_d   = total_q;
		len_d     = len_q;
		cmd_d     = cmd_q;
		dhi_d     = dhi_q;
		dlo_d     = dlo_q;
		ticks_d   = ticks_q;
		armed_d   = armed_q;
		req_valid = 1'b0;
		req.kind  = KIND_OTHER;
		req.dist_hi = '0;
		req.dist_lo = '0;
		if (accept && opcode == OP_ARM) begin
			armed_d = 1'b1;
			ticks_d = '0;
			pos_d   = '0;
		end else if (accept && opcode == OP_TICK) begin
			if (armed_q) begin
				if (ticks_q >= timeout_q) begin
					armed_d   = 1'b0;
					req_valid = 1'b1;
					req.kind  = KIND_TIMEOUT;
				end else begin
					ticks_d = ticks_q + 16'd1;
				end
			end
		end else if (is_byte) begin
			unique case (phase_q)
				PH_SYNC1: begin
					if (rx_byte == sync_first_q) begin
						cmd_d = '0;
						dhi_d = '0;
						dlo_d = '0;
						pos_d = POS_SYNC2;
					end
				end
				PH_SYNC2: pos_d = (rx_byte == sync_second_q) ? POS_LEN : '0;
				PH_LEN: begin
					len_d = rx_byte;
					if (oversize) begin
						pos_d     = '0;
						armed_d   = 1'b0;
						req_valid = 1'b1;
						req.kind  = KIND_OVERSIZE;
					end else begin
						total_d = total_sum[4:0];
						pos_d   = POS_BODY;
					end
				end
				PH_BODY: begin
					if (pos_q == POS_CMD) cmd_d = rx_byte;
					else if (pos_q == POS_DHI) dhi_d = rx_byte;
					else if (pos_q == POS_DLO) dlo_d = rx_byte;
					pos_d = pos_inc;
					if (frame_done) begin
						pos_d     = '0;
						armed_d   = 1'b0;
						req_valid = 1'b1;
						priority if (len_q == LEN_DIST && cmd_d == CMD_DIST) begin
							req.kind    = KIND_DIST;
							req.dist_hi = dhi_d;
							req.dist_lo = dlo_d;
						end else if (len_q == LEN_ACK && cmd_d == CMD_CONT_ON) begin
							req.kind = KIND_CONT_ON;
						end else if (len_q == LEN_ACK && cmd_d == CMD_CONT_OFF) begin
							req.kind = KIND_CONT_OFF;
						end else if (len_q == LEN_ACK && cmd_d == CMD_LASER) begin
							req.kind = KIND_LASER;
						end else begin
							req.kind = KIND_OTHER;
						end
					end
				end
				default: pos_d = '0;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sync_first_q  <= SYNC_FIRST_RST;
			sync_second_q <= SYNC_SECOND_RST;
			timeout_q     <= TIMEOUT_RST;
		end else if (wr_en) begin
			unique case (wr_index)
				CFG_SYNC_FIRST:  sync_first_q  <= wr_data[7:0];
				CFG_SYNC_SECOND: sync_second_q <= wr_data[7:0];
				CFG_TIMEOUT:     timeout_q     <= wr_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_SYNC1;
			pos_q   <= '0;
			total_q <= '0;
			len_q   <= '0;
			cmd_q   <= '0;
			dhi_q   <= '0;
			dlo_q   <= '0;
			ticks_q <= '0;
			armed_q <= 1'b0;
		end else begin
			phase_q <= phase_d;
			pos_q   <= pos_d;
			total_q <= total_d;
			len_q   <= len_d;
			cmd_q   <= cmd_d;
			dhi_q   <= dhi_d;
			dlo_q   <= dlo_d;
			ticks_q <= ticks_d;
			armed_q <= armed_d;
		end
	end

endmodule

>>> design/lrfp_back.sv
`timescale 1ns / 1ps

module lrfp_back (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_empty,
	input  lrfp_pkg::req_t req,
	output logic           req_pop,
	output logic           empty,
	input  logic           pop,
	output logic [2:0]     frame_kind,
	output logic [15:0]    distance_cm
);
	import lrfp_pkg::*;

	localparam int OUT_DEPTH = 2;

	res_t res, out_res;
	logic out_full;

	assign req_pop  = !req_empty && !out_full;
	assign res.kind = req.kind;
	// non-distance requests carry zero bytes, so the product is zero too
	assign res.dist_cm = {req.dist_hi, req.dist_lo} * DIST_SCALE;

	lrfp_fifo #(
		.WIDTH($bits(res_t)),
		.DEPTH(OUT_DEPTH)
	) u_out_q (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (req_pop),
		.wdata (res),
		.full  (out_full),
		.pop   (pop),
		.rdata (out_res),
		.empty (empty)
	);

	assign frame_kind  = out_res.kind;
	assign distance_cm = out_res.dist_cm;

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
	import lrfp_pkg::*;

	localparam int FRAME_MAX    = 27;
	localparam int LIMIT_CYCLES = 400000;
	localparam int DIR_ROWS     = 25;
	localparam int PHASE_ITEMS  = 170;
	localparam int PHASE_FRAMES = 10;
	localparam int HOLD_CYCLES  = 400;

	// opcode the block must ignore
	localparam logic [1:0] OP_NONE = 2'd3;

	// how a stimulus row gets its expectation
	typedef enum logic [1:0] {
		CHK_MODEL,
		CHK_NONE,
		CHK_RES
	} row_chk_t;

	typedef struct packed {
		logic [1:0]  op;
		logic [7:0]  data;
		row_chk_t    chk;
		logic [2:0]  kind;
		logic [15:0] dist_cm;
	} row_t;

	logic        clk;
	logic        arst_n  = 1'b0;
	logic        push    = 1'b0;
	logic        full;
	logic [1:0]  opcode  = OP_BYTE;
	logic [7:0]  rx_byte = 8'h00;
	logic        empty;
	logic        pop     = 1'b0;
	logic [2:0]  frame_kind;
	logic [15:0] distance_cm;
	logic        wr_en    = 1'b0;
	logic [1:0]  wr_index = CFG_SYNC_FIRST;
	logic [15:0] wr_data  = 16'd0;

	// parser copy: configuration
	logic [7:0]  cfg_sync1   = SYNC_FIRST_RST;
	logic [7:0]  cfg_sync2   = SYNC_SECOND_RST;
	logic [15:0] cfg_timeout = TIMEOUT_RST;

	// parser copy: state
	phase_t      p_phase = PH_SYNC1;
	logic [4:0]  p_pos   = 5'd0;
	logic [4:0]  p_total = 5'd0;
	logic [7:0]  p_len   = 8'd0;
	logic [7:0]  p_cmd   = 8'd0;
	logic [7:0]  p_dhi   = 8'd0;
	logic [7:0]  p_dlo   = 8'd0;
	logic [15:0] p_ticks = 16'd0;
	logic        p_armed = 1'b0;

	res_t pending_results[$];
	res_t rx_want;

	int  mismatch_count = 0;
	int  cycle_count    = 0;
	int  phase_num      = 0;
	int  phase_items    = 0;
	int  phase_results  = 0;
	bit  tx_calm        = 1'b0;
	bit  rx_calm        = 1'b0;
	bit  long_hold_done = 1'b0;
	int  rx_hold        = 0;
	int  rx_gap         = 0;

	row_t dir_tab [DIR_ROWS] = '{
		'{OP_TICK, 8'h00,           CHK_NONE,  KIND_DIST,     16'd0},
		'{OP_ARM,  8'h00,           CHK_MODEL, KIND_DIST,     16'd0},
		'{OP_TICK, 8'h00,           CHK_RES,   KIND_TIMEOUT,  16'd0},
		'{OP_TICK, 8'hFF,           CHK_NONE,  KIND_DIST,     16'd0},
		'{OP_NONE, 8'hFF,           CHK_NONE,  KIND_DIST,     16'd0},
		'{OP_BYTE, SYNC_FIRST_RST,  CHK_MODEL, KIND_DIST,     16'd0},
		// bad second sync: dropped, not taken as a new first sync
		'{OP_BYTE, SYNC_FIRST_RST,  CHK_MODEL, KIND_DIST,     16'd0},
		'{OP_BYTE, SYNC_FIRST_RST,  CHK_MODEL, KIND_DIST,     16'd0},
		'{OP_BYTE, SYNC_SECOND_RST, CHK_MODEL, KIND_DIST,     16'd0},
		'{OP_BYTE, 8'hFF,           CHK_RES,   KIND_OVERSIZE, 16'd0},
		'{OP_BYTE, SYNC_FIRST_RST,  CHK_MODEL, KIND_DIST,     16'd0},
		'{OP_BYTE, SYNC_SECOND_RST, CHK_MODEL, KIND_DIST,     16'd0},
		'{OP_BYTE, 8'h18,           CHK_RES,   KIND_OVERSIZE, 16'd0},
		'{OP_BYTE, SYNC_FIRST_RST,  CHK_MODEL, KIND_DIST,     16'd0},
		'{OP_BYTE, SYNC_SECOND_RST, CHK_MODEL, KIND_DIST,     16'd0},
		'{OP_BYTE, LEN_ACK,         CHK_MODEL, KIND_DIST,     16'd0},
		'{OP_BYTE, 8'h00,           CHK_MODEL, KIND_DIST,     16'd0},
		'{OP_BYTE, CMD_CONT_ON,     CHK_MODEL, KIND_DIST,     16'd0},
		'{OP_BYTE, 8'h00,           CHK_MODEL, KIND_DIST,     16'd0},
		'{OP_BYTE, 8'h00,           CHK_MODEL, KIND_DIST,     16'd0},
		'{OP_BYTE, 8'h00,           CHK_RES,   KIND_CONT_ON,  16'd0},
		// zero length: one body byte, command reads as cleared
		'{OP_BYTE, SYNC_FIRST_RST,  CHK_MODEL, KIND_DIST,     16'd0},
		'{OP_BYTE, SYNC_SECOND_RST, CHK_MODEL, KIND_DIST,     16'd0},
		'{OP_BYTE, 8'h00,           CHK_MODEL, KIND_DIST,     16'd0},
		'{OP_BYTE, 8'h55,           CHK_RES,   KIND_OTHER,    16'd0}
	};

	lidar_response_frame_parser_core dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (push),
		.full        (full),
		.opcode      (opcode),
		.rx_byte     (rx_byte),
		.empty       (empty),
		.pop         (pop),
		.frame_kind  (frame_kind),
		.distance_cm (distance_cm),
		.wr_en       (wr_en),
		.wr_index    (wr_index),
		.wr_data     (wr_data)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	function automatic int gap_len();
		return ($urandom_range(0, 9) == 0) ? $urandom_range(15, 50) : $urandom_range(1, 3);
	endfunction

	// one item through the parser copy; returns 1 when it yields a result
	function automatic bit parse_item(input logic [1:0] op, input logic [7:0] data,
			output res_t r);
		r = '0;
		case (op)
			OP_ARM: begin
				p_armed = 1'b1;
				p_ticks = 16'd0;
				p_phase = PH_SYNC1;
				p_pos   = 5'd0;
				return 1'b0;
			end
			OP_TICK: begin
				if (!p_armed)
					return 1'b0;
				if (p_ticks >= cfg_timeout) begin
					p_armed = 1'b0;
					r.kind  = KIND_TIMEOUT;
					return 1'b1;
				end
				p_ticks = p_ticks + 16'd1;
				return 1'b0;
			end
			OP_BYTE: ;
			default: return 1'b0;
		endcase
		case (p_phase)
			PH_SYNC1: begin
				if (data == cfg_sync1) begin
					p_cmd   = 8'd0;
					p_dhi   = 8'd0;
					p_dlo   = 8'd0;
					p_pos   = POS_SYNC2;
					p_phase = PH_SYNC2;
				end
			end
			PH_SYNC2: begin
				if (data == cfg_sync2) begin
					p_pos   = POS_LEN;
					p_phase = PH_LEN;
				end else begin
					p_pos   = 5'd0;
					p_phase = PH_SYNC1;
				end
			end
			PH_LEN: begin
				p_len = data;
				if (data > FRAME_MAX - 4) begin
					p_pos   = 5'd0;
					p_phase = PH_SYNC1;
					p_armed = 1'b0;
					r.kind  = KIND_OVERSIZE;
					return 1'b1;
				end
				p_total = 5'(data + HDR_BYTES);
				p_pos   = POS_BODY;
				p_phase = PH_BODY;
			end
			default: begin
				if (p_pos == POS_CMD)
					p_cmd = data;
				else if (p_pos == POS_DHI)
					p_dhi = data;
				else if (p_pos == POS_DLO)
					p_dlo = data;
				p_pos = p_pos + 5'd1;
				if (p_pos >= p_total) begin
					p_pos   = 5'd0;
					p_phase = PH_SYNC1;
					p_armed = 1'b0;
					if (p_len == LEN_DIST && p_cmd == CMD_DIST) begin
						r.kind    = KIND_DIST;
						r.dist_cm = {p_dhi, p_dlo} * DIST_SCALE;
					end else if (p_len == LEN_ACK && p_cmd == CMD_CONT_ON)
						r.kind = KIND_CONT_ON;
					else if (p_len == LEN_ACK && p_cmd == CMD_CONT_OFF)
						r.kind = KIND_CONT_OFF;
					else if (p_len == LEN_ACK && p_cmd == CMD_LASER)
						r.kind = KIND_LASER;
					else
						r.kind = KIND_OTHER;
					return 1'b1;
				end
			end
		endcase
		return 1'b0;
	endfunction

	task automatic report_mismatch(input string what, input logic [15:0] got,
			input logic [15:0] want);
		$display("%0t: %s: got %0h, expected %0h", $time, what, got, want);
		mismatch_count++;
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
		wr_en    <= 1'b1;
		wr_index <= idx;
		wr_data  <= val;
		@(posedge clk);
		wr_en <= 1'b0;
		case (idx)
			CFG_SYNC_FIRST:  cfg_sync1   = val[7:0];
			CFG_SYNC_SECOND: cfg_sync2   = val[7:0];
			CFG_TIMEOUT:     cfg_timeout = val;
			default: ;
		endcase
		@(posedge clk);
	endtask

	task automatic offer_row(input row_t row);
		res_t got;
		bit   hit;
		bit   counts;
		push    <= 1'b1;
		opcode  <= row.op;
		rx_byte <= row.data;
		do @(posedge clk); while (full);
		// ignored items (unarmed ticks, unused opcode) are not counted
		counts = (row.op == OP_BYTE) || (row.op == OP_ARM) || (row.op == OP_TICK && p_armed);
		hit = parse_item(row.op, row.data, got);
		if (counts)
			phase_items++;
		case (row.chk)
			CHK_MODEL: begin
				if (hit) begin
					pending_results.push_back(got);
					phase_results++;
				end
			end
			CHK_RES: pending_results.push_back(res_t'{kind: row.kind, dist_cm: row.dist_cm});
			default: ;
		endcase
		if (!tx_calm && $urandom_range(0, 3) == 0) begin
			push <= 1'b0;
			repeat (gap_len()) @(posedge clk);
		end
	endtask

	task automatic offer_item(input logic [1:0] op, input logic [7:0] data);
		offer_row(row_t'{op, data, CHK_MODEL, KIND_DIST, 16'd0});
	endtask

	task automatic send_frame();
		logic [7:0] len_v;
		logic [7:0] cmd_v;
		logic [7:0] data_v;
		int         pick;
		int         k;
		pick = $urandom_range(0, 99);
		if (pick < 40)
			len_v = LEN_DIST;
		else if (pick < 70)
			len_v = LEN_ACK;
		else if (pick < 85)
			len_v = 8'($urandom_range(0, FRAME_MAX - 4));
		else
			len_v = 8'($urandom_range(FRAME_MAX - 3, 255));
		pick = $urandom_range(0, 99);
		if (len_v == LEN_ACK)
			cmd_v = (pick < 30) ? CMD_CONT_ON : (pick < 60) ? CMD_CONT_OFF :
				(pick < 90) ? CMD_LASER : 8'($urandom);
		else
			cmd_v = (pick < 85) ? CMD_DIST : 8'($urandom);
		if ($urandom_range(0, 3) == 0)
			offer_item(OP_ARM, 8'($urandom));
		offer_item(OP_BYTE, cfg_sync1);
		if ($urandom_range(0, 19) == 0) begin
			offer_item(OP_BYTE, 8'($urandom));
			return;
		end
		offer_item(OP_BYTE, cfg_sync2);
		offer_item(OP_BYTE, len_v);
		if (len_v > FRAME_MAX - 4)
			return;
		for (k = POS_BODY; k < len_v + HDR_BYTES; k++) begin
			// truncated frame: the next frame's bytes land in its body
			if ($urandom_range(0, 39) == 0)
				return;
			if ($urandom_range(0, 11) == 0)
				offer_item(OP_TICK, 8'($urandom));
			if ($urandom_range(0, 79) == 0)
				offer_item(OP_ARM, 8'($urandom));
			pick = $urandom_range(0, 9);
			if (k == POS_CMD)
				data_v = cmd_v;
			else if (k == POS_DHI || k == POS_DLO)
				data_v = (pick < 3) ? 8'hFF : (pick < 4) ? 8'h00 : 8'($urandom);
			else
				data_v = 8'($urandom);
			offer_item(OP_BYTE, data_v);
		end
	endtask

	task automatic send_arm_wait();
		int cap;
		cap = (cfg_timeout < 40) ? cfg_timeout + 2 : 40;
		offer_item(OP_ARM, 8'($urandom));
		repeat ($urandom_range(0, cap)) offer_item(OP_TICK, 8'($urandom));
	endtask

	task automatic send_noise();
		repeat ($urandom_range(1, 6)) offer_item(2'($urandom_range(0, 3)), 8'($urandom));
	endtask

	task automatic wait_idle();
		push <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		// items with no result may still be in the pipe
		repeat (8) @(posedge clk);
	endtask

	task automatic run_phase(input int num, input logic [7:0] s1, input logic [7:0] s2,
			input logic [15:0] tmo);
		int pick;
		wait_idle();
		write_reg(CFG_SYNC_FIRST, {8'd0, s1});
		write_reg(CFG_SYNC_SECOND, {8'd0, s2});
		write_reg(CFG_TIMEOUT, tmo);
		phase_num     = num;
		phase_items   = 0;
		phase_results = 0;
		while (phase_items < PHASE_ITEMS || phase_results < PHASE_FRAMES) begin
			if ($urandom_range(0, 9) == 0)
				tx_calm = !tx_calm;
			pick = $urandom_range(0, 99);
			if (pick < 70)
				send_frame();
			else if (pick < 85)
				send_arm_wait();
			else
				send_noise();
		end
	endtask

	initial begin
		int i;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		write_reg(CFG_TIMEOUT, 16'd0);
		for (i = 0; i < DIR_ROWS; i++)
			offer_row(dir_tab[i]);
		run_phase(1, SYNC_FIRST_RST, SYNC_SECOND_RST, TIMEOUT_RST);
		run_phase(2, 8'h00, 8'hFF, 16'd5);
		run_phase(3, 8'hFF, 8'h00, 16'hFFFF);
		run_phase(4, 8'($urandom), 8'($urandom), 16'($urandom_range(0, 30)));
		run_phase(5, 8'h5A, 8'h5A, 16'd2);
		wait_idle();
		if (mismatch_count == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

	// result side: check accepted requests, then pick the next pop
	always @(posedge clk) begin
		if (arst_n && pop && !empty) begin
			if (pending_results.size() == 0)
				report_mismatch("result with nothing pending", {13'd0, frame_kind}, 16'd0);
			else begin
				rx_want = pending_results.pop_front();
				if (frame_kind !== rx_want.kind)
					report_mismatch("frame_kind", {13'd0, frame_kind}, {13'd0, rx_want.kind});
				if (distance_cm !== rx_want.dist_cm)
					report_mismatch("distance_cm", distance_cm, rx_want.dist_cm);
			end
		end
		// long hold mid-stream so the queues fill and full asserts
		if (!long_hold_done && phase_num == 2 && phase_items >= 20) begin
			long_hold_done = 1'b1;
			rx_hold        = HOLD_CYCLES;
		end
		if ($urandom_range(0, 149) == 0)
			rx_calm = !rx_calm;
		if (rx_hold > 0) begin
			rx_hold--;
			pop <= 1'b0;
		end else if (rx_gap > 0) begin
			rx_gap--;
			pop <= 1'b0;
		end else begin
			pop <= 1'b1;
			if (!rx_calm && $urandom_range(0, 3) == 0)
				rx_gap = gap_len();
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= LIMIT_CYCLES) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

endmodule

>>> lidar_response_frame_parser_core.f
design/lrfp_pkg.sv
design/lrfp_fifo.sv
design/lrfp_front.sv
design/lrfp_back.sv
design/lidar_response_frame_parser_core.sv
tb/tb_top.sv
